>>> hw/rtl/skt_pkg.sv
package skt_pkg;

    // Table geometry.
    localparam int CAPACITY  = 64;
    localparam int KEY_WIDTH = 32;
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);

    // Fixed widths of the word fields.
    localparam int KEY_FIELD_W = 32;
    localparam int SLOT_W      = 6;
    localparam int POS_W       = 7;

    typedef logic [KEY_WIDTH-1:0] t_key;
    typedef logic [IDX_W-1:0]     t_idx;
    typedef logic [CNT_W-1:0]     t_cnt;

    typedef enum logic [1:0] {
        ACT_SEARCH  = 2'd0,
        ACT_INSERT  = 2'd1,
        ACT_DEL_KEY = 2'd2,
        ACT_DEL_IDX = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_DUP      = 3'd1,
        ST_NOTFOUND = 3'd2,
        ST_RANGE    = 3'd3,
        ST_FULL     = 3'd4
    } t_status;

    typedef struct packed {
        t_action                 action;
        logic [KEY_FIELD_W-1:0]  key;
        logic [SLOT_W-1:0]       slot;
    } t_cmd;

    typedef struct packed {
        t_status           status;
        logic              found;
        logic [POS_W-1:0]  position;
        logic [POS_W-1:0]  entry_count;
    } t_result;

    // Request from the sequencer to the key store.
    typedef struct packed {
        logic  we;
        t_idx  waddr;
        t_key  wdata;
        logic  re;
        t_idx  raddr;
    } t_mem_req;

    // Outcome of one comparison of a stored key against the search key.
    typedef struct packed {
        logic precedes;
        logic equal;
    } t_cmp_res;

    // Register indexes of the configuration port.
    localparam int REG_DESC = 0;
    localparam int REG_UNIQ = 1;

endpackage

>>> hw/rtl/sorted_key_table.sv
// Sorted key table. The block holds up to 64 unsigned 32-bit keys in
// ascending or descending order and serves one request word at a time:
// search, insert, delete by key or delete by index. A word is taken when
// start is high and busy is low; busy then stays high until the result word
// appears on o_result for exactly one cycle with o_valid high. The receiver
// cannot stall, so it must capture o_result in that cycle. All keys live in
// a single memory and a single comparator walks them: finding the lower
// bound reads and compares, in turn, each entry that precedes the key (a
// delete by index skips this scan), and an insert or a delete then moves
// the later entries one at a time, each with a read and a write. The
// result word of a request appears as busy falls. A delete by index whose
// slot is out of range never raises busy: its result word appears in the
// cycle right after the request is taken. No clearing pass runs after
// reset. Configuration must be written over the APB port only while the
// block is idle; the block itself does not enforce this. Register 0 at
// address 0 selects descending order, register 1 at address 4 selects
// unique keys (reset 1).
module sorted_key_table
    import skt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        start,
    output logic        busy,
    input  t_cmd        i_cmd,

    output logic        o_valid,
    output t_result     o_result,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_CMP,
        S_DECIDE,
        S_UP_RD,
        S_UP_WR,
        S_DN_RD,
        S_DN_WR
    } t_state;

    localparam logic [2:0] ADDR_DESC = 3'(REG_DESC * 4);
    localparam logic [2:0] ADDR_UNIQ = 3'(REG_UNIQ * 4);

    t_state   r_state;
    t_action  r_action;
    t_key     r_key;
    t_cnt     r_count;
    t_cnt     r_idx;      // scan index, then the lower bound or removed position
    t_cnt     r_ptr;      // move pointer for the shift passes
    logic     r_eq;
    logic     r_desc;
    logic     r_uniq;
    logic     r_valid;
    t_result  r_result;

    t_mem_req mem_req;
    t_key     mem_rdata;
    t_cmp_res cmp_res;
    t_cnt     ptr_prev;
    t_cnt     ptr_next;
    logic     cfg_wr;

    // ------------------------------------------------------------------
    // Configuration port. Writes complete in the access phase; pready is
    // tied high so every access finishes without wait states.
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_desc <= 1'b0;
            r_uniq <= 1'b1;
        end else if (cfg_wr) begin
            if (paddr == ADDR_DESC) begin
                r_desc <= pwdata[0];
            end
            if (paddr == ADDR_UNIQ) begin
                r_uniq <= pwdata[0];
            end
        end
    end

    always_comb begin
        prdata = '0;
        unique case (paddr)
            ADDR_DESC: prdata[0] = r_desc;
            ADDR_UNIQ: prdata[0] = r_uniq;
            default:   prdata    = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Shared comparator and the key memory.
    // ------------------------------------------------------------------
    skt_cmp u_cmp (
        .i_entry (mem_rdata),
        .i_key   (r_key),
        .i_desc  (r_desc),
        .o_res   (cmp_res)
    );

    skt_store u_store (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    assign ptr_prev = r_ptr - CNT_W'(1);
    assign ptr_next = r_ptr + CNT_W'(1);

    // Memory traffic follows the sequencer state. Reads land in the memory's
    // output register, where the next state consumes them.
    always_comb begin
        mem_req       = '0;
        mem_req.wdata = mem_rdata;
        unique case (r_state)
            S_RD: begin
                mem_req.re    = 1'b1;
                mem_req.raddr = r_idx[IDX_W-1:0];
            end
            S_UP_RD: begin
                if (r_ptr == r_idx) begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = r_idx[IDX_W-1:0];
                    mem_req.wdata = r_key;
                end else begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = ptr_prev[IDX_W-1:0];
                end
            end
            S_UP_WR, S_DN_WR: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = r_ptr[IDX_W-1:0];
            end
            S_DN_RD: begin
                mem_req.re    = 1'b1;
                mem_req.raddr = ptr_next[IDX_W-1:0];
            end
            default: begin
                mem_req.we = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer. A scan walks from entry 0 until an entry no longer
    // precedes the key or the entries run out; an insert then moves entries up
    // from the top, and a delete moves entries down over the removed one.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_valid  <= 1'b0;
            r_action <= ACT_SEARCH;
            r_eq     <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_action <= i_cmd.action;
                        r_key    <= i_cmd.key[KEY_WIDTH-1:0];
                        if (i_cmd.action == ACT_DEL_IDX) begin
                            r_idx <= CNT_W'(i_cmd.slot);
                            r_ptr <= CNT_W'(i_cmd.slot);
                            r_eq  <= 1'b0;
                            if (CNT_W'(i_cmd.slot) >= r_count) begin
                                r_valid              <= 1'b1;
                                r_result.status      <= ST_RANGE;
                                r_result.found       <= 1'b0;
                                r_result.position    <= POS_W'(i_cmd.slot);
                                r_result.entry_count <= POS_W'(r_count);
                            end else begin
                                r_state <= S_DN_RD;
                            end
                        end else begin
                            r_idx   <= '0;
                            r_state <= S_RD;
                        end
                    end
                end
                S_RD: begin
                    if (r_idx >= r_count) begin
                        r_eq    <= 1'b0;
                        r_state <= S_DECIDE;
                    end else begin
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    if (cmp_res.precedes) begin
                        r_idx   <= r_idx + CNT_W'(1);
                        r_state <= S_RD;
                    end else begin
                        r_eq    <= cmp_res.equal;
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    r_result.found       <= r_eq;
                    r_result.position    <= POS_W'(r_idx);
                    r_result.entry_count <= POS_W'(r_count);
                    r_result.status      <= ST_OK;
                    unique case (r_action)
                        ACT_INSERT: begin
                            if (r_eq && r_uniq) begin
                                r_result.status <= ST_DUP;
                                r_valid         <= 1'b1;
                                r_state         <= S_IDLE;
                            end else if (r_count == CNT_W'(CAPACITY)) begin
                                r_result.status <= ST_FULL;
                                r_valid         <= 1'b1;
                                r_state         <= S_IDLE;
                            end else begin
                                r_ptr   <= r_count;
                                r_state <= S_UP_RD;
                            end
                        end
                        ACT_DEL_KEY: begin
                            if (!r_eq) begin
                                r_result.status <= ST_NOTFOUND;
                                r_valid         <= 1'b1;
                                r_state         <= S_IDLE;
                            end else begin
                                r_ptr   <= r_idx;
                                r_state <= S_DN_RD;
                            end
                        end
                        default: begin
                            r_valid <= 1'b1;
                            r_state <= S_IDLE;
                        end
                    endcase
                end
                S_UP_RD: begin
                    if (r_ptr == r_idx) begin
                        // The new key goes into the opened slot this cycle.
                        r_count              <= r_count + CNT_W'(1);
                        r_valid              <= 1'b1;
                        r_result.status      <= ST_OK;
                        r_result.found       <= r_eq;
                        r_result.position    <= POS_W'(r_idx);
                        r_result.entry_count <= POS_W'(r_count + CNT_W'(1));
                        r_state              <= S_IDLE;
                    end else begin
                        r_state <= S_UP_WR;
                    end
                end
                S_UP_WR: begin
                    r_ptr   <= ptr_prev;
                    r_state <= S_UP_RD;
                end
                S_DN_RD: begin
                    if (ptr_next >= r_count) begin
                        r_count              <= r_count - CNT_W'(1);
                        r_valid              <= 1'b1;
                        r_result.status      <= ST_OK;
                        r_result.found       <= r_eq;
                        r_result.position    <= POS_W'(r_idx);
                        r_result.entry_count <= POS_W'(r_count - CNT_W'(1));
                        r_state              <= S_IDLE;
                    end else begin
                        r_state <= S_DN_WR;
                    end
                end
                S_DN_WR: begin
                    r_ptr   <= ptr_next;
                    r_state <= S_DN_RD;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_result;

`ifndef SYNTHESIS
    // A result word is only ever shown while the sequencer is idle.
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result word shown while the sequencer is busy");

    // An accepted request either occupies the sequencer in the next cycle or,
    // for an out-of-range index, returns its result word right away.
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_valid))
        else $error("accepted request did not start the sequencer");

    // The fill count never passes the table size.
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count exceeds capacity");

    // The reported entry count matches the table state it leaves behind.
    a_count_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_result.entry_count == POS_W'(r_count)))
        else $error("reported entry count disagrees with the table");
`endif

endmodule

>>> hw/rtl/skt_cmp.sv
module skt_cmp
    import skt_pkg::*;
(
    input  t_key     i_entry,
    input  t_key     i_key,
    input  logic     i_desc,
    output t_cmp_res o_res
);

    // The stored entry precedes the key when it sorts strictly before it
    // in the current order.
    always_comb begin
        o_res.precedes = i_desc ? (i_entry > i_key) : (i_entry < i_key);
        o_res.equal    = (i_entry == i_key);
    end

endmodule

>>> hw/rtl/skt_store.sv
module skt_store
    import skt_pkg::*;
(
    input  logic     i_clk,
    input  t_mem_req i_req,
    output t_key     o_rdata
);

    t_key r_mem [CAPACITY];
    t_key r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
